### design/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg: shared types and constants for the pixel block mosaic
// Pixel layout, register field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package pbm_pkg;

   // pixel layout: channel 0 in the low byte
   localparam int CHAN_W   = 8;
   localparam int CHANNELS = 3;
   localparam int PIX_W    = CHANNELS * CHAN_W;

   // register field widths
   localparam int BLOCK_W  = 10;
   localparam int DIM_W    = 11;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RST   = BLOCK_W'(1);
   localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = DIM_W'(640);
   localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = DIM_W'(480);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE   = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

endpackage

### design/pixel_block_mosaic.sv
// ----------------------------------------------------------------------------
// pixel_block_mosaic: block mosaic filter over a raster pixel stream
// A result passes through the read stage and the output register before it is offered.
// Throughput: one pixel per cycle while the output is not stalled; the row
// store takes one read and at most one write per transfer.
// Reset clears the counters and the pipeline and loads the register defaults;
// the row store is not cleared and needs no pass, so the block is ready at once.
// ----------------------------------------------------------------------------
module pixel_block_mosaic #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_we,
   input  logic [pbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pbm_pkg::CSR_W-1:0]     csr_wdata,
   // pixel input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pbm_pkg::CHAN_W-1:0]    req_in_channel_0,
   input  logic [pbm_pkg::CHAN_W-1:0]    req_in_channel_1,
   input  logic [pbm_pkg::CHAN_W-1:0]    req_in_channel_2,
   // pixel output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pbm_pkg::CHAN_W-1:0]    rsp_out_channel_0,
   output logic [pbm_pkg::CHAN_W-1:0]    rsp_out_channel_1,
   output logic [pbm_pkg::CHAN_W-1:0]    rsp_out_channel_2,
   output logic                          rsp_end_of_frame
);
   import pbm_pkg::*;

   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCMP_W  = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
   localparam int HCMP_W  = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;
   localparam int ECMP_W  = BLOCK_W + 1;

   // configuration registers
   logic [BLOCK_W-1:0] block_size_ff;
   logic [DIM_W-1:0]   image_width_ff;
   logic [DIM_W-1:0]   image_height_ff;

   // position counters
   logic [COL_W-1:0]   column_count_ff, column_count_in;
   logic [ROW_W-1:0]   row_count_ff, row_count_in;
   logic [BLOCK_W-1:0] column_in_block_ff, column_in_block_in;
   logic [BLOCK_W-1:0] row_in_block_ff, row_in_block_in;
   logic [COL_W-1:0]   block_column_ff, block_column_in;

   // row store and its read register
   logic [PIX_W-1:0]   store_mem [MAX_WIDTH];
   logic [PIX_W-1:0]   read_data_ff;

   // read stage
   logic               s1_valid_ff;
   logic               s1_fwd_ff;
   logic               s1_eof_ff;
   logic [PIX_W-1:0]   s1_pixel_ff;

   // output register
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_pixel_ff;
   logic               rsp_eof_ff;

   logic               accept;
   logic               s1_advance;
   logic [PIX_W-1:0]   pixel;
   logic [WCMP_W-1:0]  width_lim;
   logic [HCMP_W-1:0]  height_lim;
   logic [ECMP_W-1:0]  edge_len;
   logic               first_pixel;
   logic               last_col;
   logic               last_row;
   logic               col_block_end;
   logic               row_block_end;

   // register writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff   <= BLOCK_SIZE_RST;
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BLOCK_SIZE:   block_size_ff   <= csr_wdata[BLOCK_W-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: the read stage moves on when the output register frees up
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   assign pixel = {req_in_channel_2, req_in_channel_1, req_in_channel_0};

   // effective frame limits and block edge
   always_comb begin
      if (image_width_ff == '0 || WCMP_W'(image_width_ff) > WCMP_W'(MAX_WIDTH)) begin
         width_lim = WCMP_W'(MAX_WIDTH);
      end else begin
         width_lim = WCMP_W'(image_width_ff);
      end
      if (image_height_ff == '0 || HCMP_W'(image_height_ff) > HCMP_W'(MAX_HEIGHT)) begin
         height_lim = HCMP_W'(MAX_HEIGHT);
      end else begin
         height_lim = HCMP_W'(image_height_ff);
      end
      edge_len = (block_size_ff < BLOCK_W'(2)) ? ECMP_W'(1) : ECMP_W'(block_size_ff);
   end

   assign first_pixel   = (row_in_block_ff == '0) && (column_in_block_ff == '0);
   assign last_col      = (WCMP_W'(column_count_ff) + WCMP_W'(1)) >= width_lim;
   assign last_row      = (HCMP_W'(row_count_ff) + HCMP_W'(1)) >= height_lim;
   assign col_block_end = (ECMP_W'(column_in_block_ff) + ECMP_W'(1)) >= edge_len;
   assign row_block_end = (ECMP_W'(row_in_block_ff) + ECMP_W'(1)) >= edge_len;

   // advance the position counters, wrapping at row, block and frame edges
   always_comb begin
      column_count_in    = column_count_ff;
      row_count_in       = row_count_ff;
      column_in_block_in = column_in_block_ff;
      row_in_block_in    = row_in_block_ff;
      block_column_in    = block_column_ff;
      if (last_col) begin
         column_count_in    = '0;
         column_in_block_in = '0;
         block_column_in    = '0;
         if (last_row) begin
            row_count_in    = '0;
            row_in_block_in = '0;
         end else begin
            row_count_in    = row_count_ff + ROW_W'(1);
            row_in_block_in = row_block_end ? '0 : row_in_block_ff + BLOCK_W'(1);
         end
      end else begin
         column_count_in = column_count_ff + COL_W'(1);
         if (col_block_end) begin
            column_in_block_in = '0;
            block_column_in    = block_column_ff + COL_W'(1);
         end else begin
            column_in_block_in = column_in_block_ff + BLOCK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff    <= '0;
         row_count_ff       <= '0;
         column_in_block_ff <= '0;
         row_in_block_ff    <= '0;
         block_column_ff    <= '0;
      end else if (accept) begin
         column_count_ff    <= column_count_in;
         row_count_ff       <= row_count_in;
         column_in_block_ff <= column_in_block_in;
         row_in_block_ff    <= row_in_block_in;
         block_column_ff    <= block_column_in;
      end
   end

   // row store: write the top-left pixel of a block, read the slot on every
   // transfer; the read register holds while the read stage stalls
   always_ff @(posedge clock) begin
      if (accept) begin
         if (first_pixel) begin
            store_mem[block_column_ff] <= pixel;
         end
         read_data_ff <= store_mem[block_column_ff];
      end
   end

   // read stage; a block's first pixel forwards itself past the store
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_fwd_ff   <= first_pixel;
         s1_eof_ff   <= last_col && last_row;
         s1_pixel_ff <= pixel;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_pixel_ff <= s1_fwd_ff ? s1_pixel_ff : read_data_ff;
         rsp_eof_ff   <= s1_eof_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel_0 = rsp_pixel_ff[CHAN_W-1:0];
   assign rsp_out_channel_1 = rsp_pixel_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_out_channel_2 = rsp_pixel_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_end_of_frame  = rsp_eof_ff;

   // the block column never runs ahead of the pixel column
   a_block_col_bound: assert property (@(posedge clock) disable iff (reset)
      block_column_ff <= column_count_ff)
      else $error("block column ahead of column count");

   // a full pipeline with a stalled output takes no new pixel
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline is full");

   // the first pixel of a block is forwarded, not read from the store
   a_first_forwards: assert property (@(posedge clock) disable iff (reset)
      accept && first_pixel |=> s1_valid_ff && s1_fwd_ff)
      else $error("block top-left pixel not forwarded");

   // the last pixel of a frame returns the counters to the top-left corner
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && last_col && last_row |=>
         column_count_ff == '0 && row_count_ff == '0 && first_pixel)
      else $error("counters did not wrap at end of frame");

endmodule

### test/pixel_block_mosaic_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_block_mosaic_test: self-checking bench for the pixel block mosaic
// Streams raster pixels through the filter under several block and frame
// settings, predicts each output pixel and its end-of-frame flag in a
// scoreboard, and compares every result transfer in order. Both channels
// idle and stall in random bursts; registers change only while idle.
// ----------------------------------------------------------------------------
module pixel_block_mosaic_test;
   import pbm_pkg::*;

   localparam int MAX_W        = 1024;
   localparam int MAX_H        = 1024;
   localparam int SLOT_W       = $clog2(MAX_W);
   localparam int SETTLE       = 4;
   localparam int RANDOM_ITEMS = 1300;
   localparam int QUIET_FROM   = 1150;
   localparam int IDLE_LIMIT   = 2000;

   typedef struct packed {
      logic [CHAN_W-1:0] ch0;
      logic [CHAN_W-1:0] ch1;
      logic [CHAN_W-1:0] ch2;
      logic              eof;
   } mosaic_pixel_type;

   // scoreboard: tracks frame position and block corners, holds expected pixels
   class mosaic_tracker;
      logic [BLOCK_W-1:0] tile_size;
      logic [DIM_W-1:0]   frame_w;
      logic [DIM_W-1:0]   frame_h;
      int unsigned        col_pos, row_pos, col_in_tile, row_in_tile, tile_col;
      logic [PIX_W-1:0]   tile_corner [MAX_W];
      mosaic_pixel_type   expected_pixels [$];
      int                 failures;

      function new();
         tile_size   = BLOCK_SIZE_RST;
         frame_w     = IMAGE_WIDTH_RST;
         frame_h     = IMAGE_HEIGHT_RST;
         col_pos     = 0;
         row_pos     = 0;
         col_in_tile = 0;
         row_in_tile = 0;
         tile_col    = 0;
         failures    = 0;
         foreach (tile_corner[i]) tile_corner[i] = '0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_BLOCK_SIZE:   tile_size = value[BLOCK_W-1:0];
            CSR_IMAGE_WIDTH:  frame_w   = value[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: frame_h   = value[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function bit at_frame_start();
         return col_pos == 0 && row_pos == 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // predict the output for one accepted pixel and advance the counters
      function void note_pixel(logic [CHAN_W-1:0] c0, c1, c2);
         int unsigned       fw, fh, bs, width, height, span;
         logic [SLOT_W-1:0] slot;
         logic [PIX_W-1:0]  pix, corner;
         bit                last_col, last_row;
         mosaic_pixel_type  want;
         fw     = 32'(frame_w);
         fh     = 32'(frame_h);
         bs     = 32'(tile_size);
         width  = (fw == 0 || fw > MAX_W) ? MAX_W : fw;
         height = (fh == 0 || fh > MAX_H) ? MAX_H : fh;
         span   = (bs < 2) ? 1 : bs;
         slot   = SLOT_W'((tile_col < MAX_W) ? tile_col : MAX_W - 1);
         pix    = {c2, c1, c0};
         // the block's first pixel becomes its corner and is forwarded
         if (row_in_tile == 0 && col_in_tile == 0) begin
            tile_corner[slot] = pix;
            corner = pix;
         end else begin
            corner = tile_corner[slot];
         end
         last_col = (col_pos + 1 >= width);
         last_row = (row_pos + 1 >= height);
         want.ch0 = corner[7:0];
         want.ch1 = corner[15:8];
         want.ch2 = corner[23:16];
         want.eof = last_col && last_row;
         expected_pixels.push_back(want);
         if (last_col) begin
            col_pos     = 0;
            col_in_tile = 0;
            tile_col    = 0;
            if (last_row) begin
               row_pos     = 0;
               row_in_tile = 0;
            end else begin
               row_pos++;
               row_in_tile = (row_in_tile + 1 >= span) ? 0 : row_in_tile + 1;
            end
         end else begin
            col_pos++;
            if (col_in_tile + 1 >= span) begin
               col_in_tile = 0;
               tile_col++;
            end else begin
               col_in_tile++;
            end
         end
      endfunction

      // compare one result transfer with the oldest prediction
      function void check_pixel(mosaic_pixel_type got);
         mosaic_pixel_type want;
         if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: ch0=%h ch1=%h ch2=%h eof=%b",
                        got.ch0, got.ch1, got.ch2, got.eof);
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected ch0=%h ch1=%h ch2=%h eof=%b,",
                        want.ch0, want.ch1, want.ch2, want.eof,
                        " got ch0=%h ch1=%h ch2=%h eof=%b",
                        got.ch0, got.ch1, got.ch2, got.eof);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   logic [CHAN_W-1:0]    req_in_channel_0;
   logic [CHAN_W-1:0]    req_in_channel_1;
   logic [CHAN_W-1:0]    req_in_channel_2;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [CHAN_W-1:0]    rsp_out_channel_0;
   logic [CHAN_W-1:0]    rsp_out_channel_1;
   logic [CHAN_W-1:0]    rsp_out_channel_2;
   logic                 rsp_end_of_frame;

   mosaic_tracker tracker = new();
   int            random_items = 0;
   bit            quiet = 1'b0;

   pixel_block_mosaic u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_channel_0  (req_in_channel_0),
      .req_in_channel_1  (req_in_channel_1),
      .req_in_channel_2  (req_in_channel_2),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_channel_0 (rsp_out_channel_0),
      .rsp_out_channel_1 (rsp_out_channel_1),
      .rsp_out_channel_2 (rsp_out_channel_2),
      .rsp_end_of_frame  (rsp_end_of_frame)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [CHAN_W-1:0] random_byte();
      return CHAN_W'($urandom);
   endfunction

   // offer one pixel, optionally after an idle burst, and hold it until the transfer
   task automatic send_pixel(input logic [CHAN_W-1:0] c0, c1, c2);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_channel_0 <= c0;
      req_in_channel_1 <= c1;
      req_in_channel_2 <= c2;
      do @(posedge clock); while (!req_ready);
      tracker.note_pixel(c0, c1, c2);
   endtask

   // drop valid and hold until every predicted pixel has come back
   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      tracker.set_register(idx, CSR_W'(value));
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup(input int block, input int width, input int height);
      wait_idle(SETTLE);
      write_register(CSR_BLOCK_SIZE, block);
      write_register(CSR_IMAGE_WIDTH, width);
      write_register(CSR_IMAGE_HEIGHT, height);
   endtask

   // stream random pixels until the frame wraps back to its top-left corner
   task automatic send_frame(input bit counted);
      do begin
         send_pixel(random_byte(), random_byte(), random_byte());
         if (counted) begin
            random_items++;
            quiet = (random_items >= QUIET_FROM);
         end
         if (!quiet && $urandom_range(0, 199) == 0) wait_idle(0);
      end while (!tracker.at_frame_start());
   endtask

   // result side: random stall bursts, then always ready near the end
   initial begin
      int stall;
      stall = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 12) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_pixel({rsp_out_channel_0, rsp_out_channel_1,
                              rsp_out_channel_2, rsp_end_of_frame});
   end

   // watchdog: end the run after too long without any transfer
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int phase, block, width, height, frames;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_BLOCK_SIZE;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_in_channel_0 <= '0;
      req_in_channel_1 <= '0;
      req_in_channel_2 <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass-through with extreme channel values
      setup(0, 2, 2);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hff, 8'hff, 8'hff);
      send_pixel(8'haa, 8'h55, 8'haa);
      send_pixel(8'h55, 8'haa, 8'h55);

      // partial blocks at the right edge
      setup(2, 3, 2);
      send_frame(1'b0);

      // block larger than the frame: one corner repeated
      setup(1023, 3, 2);
      send_frame(1'b0);

      // one-pixel frames
      setup(1, 1, 1);
      send_frame(1'b0);
      send_frame(1'b0);

      // width out of range acts as the maximum; shrink it mid-row to wrap
      setup(3, 0, 1);
      repeat (5) send_pixel(random_byte(), random_byte(), random_byte());
      wait_idle(SETTLE);
      write_register(CSR_IMAGE_WIDTH, 5);
      send_frame(1'b0);
      wait_idle(SETTLE);
      write_register(CSR_IMAGE_WIDTH, 2047);
      repeat (3) send_pixel(random_byte(), random_byte(), random_byte());
      wait_idle(SETTLE);
      write_register(CSR_IMAGE_WIDTH, 2);
      send_frame(1'b0);

      // height out of range and at the maximum; shrink it mid-frame to wrap
      setup(2, 1, 0);
      repeat (2) send_pixel(random_byte(), random_byte(), random_byte());
      wait_idle(SETTLE);
      write_register(CSR_IMAGE_HEIGHT, 2047);
      send_pixel(random_byte(), random_byte(), random_byte());
      wait_idle(SETTLE);
      write_register(CSR_IMAGE_HEIGHT, 1024);
      send_pixel(random_byte(), random_byte(), random_byte());
      wait_idle(SETTLE);
      write_register(CSR_IMAGE_HEIGHT, 2);
      send_frame(1'b0);

      // random settings, mostly small frames, one full-width row once
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase == 4) begin
            case ($urandom_range(0, 2))
               0:       width = 1024;
               1:       width = 0;
               default: width = $urandom_range(1025, 2047);
            endcase
            setup($urandom_range(0, 1023), width, 1);
            send_frame(1'b1);
         end
         case ($urandom_range(0, 7))
            0:       block = 0;
            1:       block = 1;
            2:       block = 1023;
            3:       block = $urandom_range(0, 2047);
            default: block = $urandom_range(2, 6);
         endcase
         width  = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
         height = $urandom_range(1, 8);
         frames = $urandom_range(1, 3);
         setup(block, width, height);
         repeat (frames) send_frame(1'b1);
         phase++;
      end

      wait_idle(8);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
design/pbm_pkg.sv
design/pixel_block_mosaic.sv
test/pixel_block_mosaic_test.sv
